// File: rtl/base64_stream_decoder_core_macros.svh
// assertion macros for the base64 stream decoder
// no dependencies; included by the top level only
`ifndef BASE64_STREAM_DECODER_CORE_MACROS_SVH
`define BASE64_STREAM_DECODER_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, quiet during reset
`define B64D_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define B64D_ASSERT_IMPLY(lbl, ante, cons, msg)
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/b64d_pkg.sv
// types, codes and the symbol table of the base64 stream decoder
// no dependencies
`default_nettype none

package b64d_pkg;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] PAD_CODE     = 8'h3D;
    localparam logic [7:0] PLUS_CODE    = 8'h2B;
    localparam logic [7:0] SLASH_CODE   = 8'h2F;

    localparam logic [1:0] ST_BYTE    = 2'd0;
    localparam logic [1:0] ST_BAD_CHR = 2'd1;
    localparam logic [1:0] ST_BAD_LEN = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // bit 6 set marks a character outside the alphabet
    localparam logic [6:0] BAD_SYMBOL = 7'd64;

    typedef struct packed {
        logic [7:0] char_code;
        logic       stream_last;
    } char_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] status;
        logic       run_last;
        logic       stream_done;
    } result_t;

    // one unit of work for the back end: up to three results
    typedef struct packed {
        logic [23:0] bytes;
        logic [1:0]  count;
        logic [1:0]  status;
        logic        done;
    } job_t;

    function automatic logic [6:0] symbol_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h61 + 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30 + 8'd52;
        end else if (c == PLUS_CODE) begin
            d = 8'd62;
        end else if (c == SLASH_CODE) begin
            d = 8'd63;
        end else if (c == PAD_CODE) begin
            d = 8'd0;
        end else begin
            d = {1'b0, BAD_SYMBOL};
        end
        return d[6:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/b64d_front.sv
// front end: takes characters, tracks group state, issues jobs
// depends on b64d_pkg
`default_nettype none

module b64d_front
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire b64d_pkg::char_item_t item,
    output logic                     push,
    output b64d_pkg::job_t           job
);

    logic [1:0]  pos_reg, pos_next;
    logic [17:0] acc_reg, acc_next;
    logic        third_pad_reg, third_pad_next;
    logic [23:0] held_reg, held_next;
    logic        held_valid_reg, held_valid_next;
    logic [1:0]  drop_reg, drop_next;
    logic        failed_reg, failed_next;

    logic [6:0]  sym;
    logic        is_nl;
    logic        is_pad;
    logic        last;

    assign sym    = b64d_pkg::symbol_value(item.char_code);
    assign is_nl  = (item.char_code == b64d_pkg::NEWLINE_CODE);
    assign is_pad = (item.char_code == b64d_pkg::PAD_CODE);
    assign last   = item.stream_last;

    always_comb
    begin
        pos_next        = pos_reg;
        acc_next        = acc_reg;
        third_pad_next  = third_pad_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        drop_next       = drop_reg;
        failed_next     = failed_reg;
        push            = 1'b0;
        job             = '0;

        if (accept) begin
            if (failed_reg) begin
                // swallow everything until the end of the stream
                if (last) begin
                    failed_next = 1'b0;
                end
            end else if (!is_nl && sym[6]) begin
                push            = 1'b1;
                job.count       = 2'd1;
                job.status      = b64d_pkg::ST_BAD_CHR;
                job.done        = 1'b1;
                pos_next        = '0;
                acc_next        = '0;
                third_pad_next  = 1'b0;
                held_next       = '0;
                held_valid_next = 1'b0;
                drop_next       = '0;
                failed_next     = !last;
            end else begin
                if (!is_nl) begin
                    // a new group starts: release the held one in full
                    if (pos_reg == 2'd0 && held_valid_reg && !last) begin
                        push            = 1'b1;
                        job.bytes       = held_reg;
                        job.count       = 2'd3;
                        job.status      = b64d_pkg::ST_BYTE;
                        job.done        = 1'b0;
                        held_valid_next = 1'b0;
                    end
                    if (pos_reg == 2'd3) begin
                        held_next       = {acc_reg, sym[5:0]};
                        held_valid_next = 1'b1;
                        drop_next       = third_pad_reg ? 2'd2 : (is_pad ? 2'd1 : 2'd0);
                        acc_next        = '0;
                        third_pad_next  = 1'b0;
                        pos_next        = '0;
                    end else begin
                        if (pos_reg == 2'd2) begin
                            third_pad_next = is_pad;
                        end
                        acc_next = {acc_reg[11:0], sym[5:0]};
                        pos_next = pos_reg + 2'd1;
                    end
                end
                if (last) begin
                    push     = 1'b1;
                    job.done = 1'b1;
                    priority if (pos_next != 2'd0) begin
                        job.count  = 2'd1;
                        job.status = b64d_pkg::ST_BAD_LEN;
                    end else if (!held_valid_next) begin
                        job.count  = 2'd1;
                        job.status = b64d_pkg::ST_EMPTY;
                    end else begin
                        job.bytes  = held_next;
                        job.count  = 2'd3 - drop_next;
                        job.status = b64d_pkg::ST_BYTE;
                    end
                    pos_next        = '0;
                    acc_next        = '0;
                    third_pad_next  = 1'b0;
                    held_next       = '0;
                    held_valid_next = 1'b0;
                    drop_next       = '0;
                    failed_next     = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg        <= '0;
            acc_reg        <= '0;
            third_pad_reg  <= 1'b0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            drop_reg       <= '0;
            failed_reg     <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            acc_reg        <= acc_next;
            third_pad_reg  <= third_pad_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            drop_reg       <= drop_next;
            failed_reg     <= failed_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/b64d_queue.sv
// short job queue between front and back end
// depends on b64d_pkg
`default_nettype none

module b64d_queue
#(
    parameter int DEPTH = 4
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire b64d_pkg::job_t push_job,
    input  wire logic           pop,
    output b64d_pkg::job_t      head_job,
    output logic                full,
    output logic                empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64d_pkg::job_t mem_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/b64d_back.sv
// back end: turns each job into one to three results
// depends on b64d_pkg
`default_nettype none

module b64d_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire b64d_pkg::job_t head_job,
    output logic                pop,
    output logic                res_valid,
    input  wire logic           res_stall,
    output b64d_pkg::result_t   res_data
);

    logic           busy_reg, busy_next;
    b64d_pkg::job_t job_reg, job_next;
    logic [1:0]     idx_reg, idx_next;

    logic           take;
    logic           final_res;
    logic [7:0]     sel_byte;

    assign take      = busy_reg && !res_stall;
    assign final_res = ((idx_reg + 2'd1) == job_reg.count);
    assign pop       = !q_empty && (!busy_reg || (take && final_res));
    assign res_valid = busy_reg;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sel_byte = job_reg.bytes[23:16];
            2'd1:    sel_byte = job_reg.bytes[15:8];
            2'd2:    sel_byte = job_reg.bytes[7:0];
            default: sel_byte = '0;
        endcase
    end

    always_comb
    begin
        res_data.data_byte   = (job_reg.status == b64d_pkg::ST_BYTE) ? sel_byte : 8'd0;
        res_data.status      = job_reg.status;
        res_data.run_last    = final_res;
        res_data.stream_done = final_res && job_reg.done;
    end

    always_comb
    begin
        busy_next = busy_reg;
        job_next  = job_reg;
        idx_next  = idx_reg;
        if (pop) begin
            busy_next = 1'b1;
            job_next  = head_job;
            idx_next  = '0;
        end else if (take) begin
            if (final_res) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/base64_stream_decoder_core.sv
// top level of the base64 stream decoder: front end, job queue, back end
// depends on b64d_pkg, b64d_front, b64d_queue, b64d_back and the macro header
//
//   channel   dir   handshake              payload
//   char      in    char_valid/char_stall  char_data (char_code, stream_last)
//   res       out   res_valid/res_stall    res_data (data_byte, status, run_last, stream_done)
//
// one character is taken per cycle unless char_stall is high; each transfer is classified in that cycle
// a group of four symbols gives up to three result transfers, one per cycle while res_stall is low, from the back end
// char_stall rises only when the job queue is full, so a stalled result side
// holds off input after QUEUE_DEPTH jobs plus the one being sent
// asynchronous reset clears all control state; no clearing pass is needed
`default_nettype none

`include "base64_stream_decoder_core_macros.svh"

module base64_stream_decoder_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 char_valid,
    output logic                      char_stall,
    input  wire b64d_pkg::char_item_t char_data,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output b64d_pkg::result_t         res_data
);

    logic           char_take;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    b64d_pkg::job_t push_job;
    b64d_pkg::job_t head_job;

    // the front end only waits for room in the queue
    assign char_stall = q_full;
    assign char_take  = char_valid && !char_stall;

    // group tracking and end-of-stream decisions
    b64d_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (char_take),
        .item   (char_data),
        .push   (q_push),
        .job    (push_job)
    );

    // decouples the character side from the result side
    b64d_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    // result serialiser with registered job and index
    b64d_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head_job  (head_job),
        .pop       (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // no job may be written into a full queue
    `B64D_ASSERT_IMPLY(a_no_overflow, q_full, !q_push, "job queue overflow")
    // the back end never pops an empty queue
    `B64D_ASSERT_IMPLY(a_no_underflow, q_empty, !q_pop, "job queue underflow")
    // error results are single, zero and close the stream
    `B64D_ASSERT_IMPLY(a_error_shape,
        res_valid && (res_data.status != b64d_pkg::ST_BYTE),
        res_data.run_last && res_data.stream_done && (res_data.data_byte == 8'd0),
        "malformed error result")
    // a result still waiting after a stall stays offered
    `B64D_ASSERT_NEXT(a_result_kept, res_valid && res_stall, res_valid,
        "pending result withdrawn")

endmodule

`default_nettype wire

// File: test/tb_base64_stream_decoder_core.sv
// self-checking testbench for base64_stream_decoder_core
// depends on b64d_pkg and the decoder rtl; predicts every result transfer in step with input
`default_nettype none

module tb_base64_stream_decoder_core;

    // longest run of cycles with no transfer on either channel before the run is abandoned
    localparam int QUIET_LIMIT  = 4000;
    // cycles allowed after the last expected result for stray transfers to show up
    localparam int DRAIN_CYCLES = 16;
    // minimum characters per idling phase, four phases
    localparam int PHASE_ITEMS  = 48;

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 char_valid = 1'b0;
    logic                 char_stall;
    b64d_pkg::char_item_t char_data  = '0;
    logic                 res_valid;
    logic                 res_stall  = 1'b0;
    b64d_pkg::result_t    res_data;

    // idling controls, percent of cycles
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    int mismatches   = 0;
    int quiet_cycles = 0;

    // results still owed by the decoder, oldest first
    b64d_pkg::result_t decoded_queue[$];

    // decoder state as the predictor sees it
    logic [1:0]  grp_pos;
    logic [17:0] sextet_acc;
    logic        third_pad;
    logic [23:0] held_group;
    logic        held_ok;
    logic [1:0]  held_trim;
    logic        discarding;

    string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    base64_stream_decoder_core u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // sextet of a character; bit 6 set means outside the alphabet
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd64;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            v = c - 8'h41;
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            v = c - 8'h61 + 8'd26;
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30 + 8'd52;
        end
        else if (c == b64d_pkg::PLUS_CODE)
        begin
            v = 8'd62;
        end
        else if (c == b64d_pkg::SLASH_CODE)
        begin
            v = 8'd63;
        end
        else if (c == b64d_pkg::PAD_CODE)
        begin
            v = 8'd0;
        end
        return v[6:0];
    endfunction

    function automatic void clear_decoder();
        grp_pos    = '0;
        sextet_acc = '0;
        third_pad  = 1'b0;
        held_group = '0;
        held_ok    = 1'b0;
        held_trim  = '0;
        discarding = 1'b0;
    endfunction

    function automatic void owe_result(input logic [7:0] data, input logic [1:0] status,
                                       input logic run_end, input logic done);
        b64d_pkg::result_t r;
        r.data_byte   = data;
        r.status      = status;
        r.run_last    = run_end;
        r.stream_done = done;
        decoded_queue.push_back(r);
    endfunction

    // works out the results of one accepted character transfer
    function automatic void predict_decode(input b64d_pkg::char_item_t item);
        logic [6:0] v;
        int         keep;
        v = sextet_of(item.char_code);

        // after an error everything up to the end of the stream is thrown away
        if (discarding)
        begin
            if (item.stream_last)
            begin
                clear_decoder();
            end
            return;
        end

        if (item.char_code != b64d_pkg::NEWLINE_CODE)
        begin
            if (v[6])
            begin
                clear_decoder();
                discarding = !item.stream_last;
                owe_result(8'h00, b64d_pkg::ST_BAD_CHR, 1'b1, 1'b1);
                return;
            end
            // first symbol of a new group releases the held group in full
            if (grp_pos == 2'd0 && held_ok && !item.stream_last)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    owe_result(held_group[23 - 8 * i -: 8], b64d_pkg::ST_BYTE, i == 2, 1'b0);
                end
                held_ok = 1'b0;
            end
            if (grp_pos == 2'd3)
            begin
                held_group = {sextet_acc, v[5:0]};
                held_ok    = 1'b1;
                held_trim  = third_pad ? 2'd2
                           : (item.char_code == b64d_pkg::PAD_CODE ? 2'd1 : 2'd0);
                sextet_acc = '0;
                third_pad  = 1'b0;
                grp_pos    = 2'd0;
            end
            else
            begin
                if (grp_pos == 2'd2)
                begin
                    third_pad = (item.char_code == b64d_pkg::PAD_CODE);
                end
                sextet_acc = {sextet_acc[11:0], v[5:0]};
                grp_pos    = grp_pos + 2'd1;
            end
        end

        if (item.stream_last)
        begin
            // a partial group wins over the held one
            if (grp_pos != 2'd0)
            begin
                owe_result(8'h00, b64d_pkg::ST_BAD_LEN, 1'b1, 1'b1);
            end
            else if (!held_ok)
            begin
                owe_result(8'h00, b64d_pkg::ST_EMPTY, 1'b1, 1'b1);
            end
            else
            begin
                keep = 3 - held_trim;
                for (int i = 0; i < keep; i++)
                begin
                    owe_result(held_group[23 - 8 * i -: 8], b64d_pkg::ST_BYTE,
                               i == keep - 1, i == keep - 1);
                end
            end
            clear_decoder();
        end
    endfunction

    // ------------------------------------------------------------------
    // result side: random stall and the checker
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        res_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    always @(posedge clk)
    begin
        b64d_pkg::result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (decoded_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result: byte %02h status %0d run_last %0b done %0b",
                             res_data.data_byte, res_data.status, res_data.run_last,
                             res_data.stream_done);
                end
            end
            else
            begin
                want = decoded_queue.pop_front();
                if (res_data.data_byte !== want.data_byte || res_data.status !== want.status
                    || res_data.run_last !== want.run_last
                    || res_data.stream_done !== want.stream_done)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp byte %02h status %0d run_last %0b done %0b",
                                 want.data_byte, want.status, want.run_last,
                                 want.stream_done);
                        $display("          got byte %02h status %0d run_last %0b done %0b",
                                 res_data.data_byte, res_data.status, res_data.run_last,
                                 res_data.stream_done);
                    end
                end
            end
        end
    end

    // watchdog: nothing moving on either channel for too long means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (char_valid && !char_stall) || (res_valid && !res_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // character side
    // ------------------------------------------------------------------

    // one character transfer, with random gaps in front of it
    task automatic send_char(input logic [7:0] code, input logic last);
        b64d_pkg::char_item_t item;
        item.char_code   = code;
        item.stream_last = last;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= item;
        @(posedge clk);
        while (char_stall)
        begin
            @(posedge clk);
        end
        predict_decode(item);
    endtask

    // whole stream from a string, last flag on its final character
    task automatic send_stream(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    // sender holds off until the decoder owes nothing, then waits out the drain period
    task automatic wait_for_results();
        char_valid <= 1'b0;
        while (decoded_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] random_symbol();
        return alphabet[$urandom_range(0, 63)];
    endfunction

    function automatic logic [7:0] random_bad_byte();
        logic [7:0] c;
        logic [6:0] v;
        do
        begin
            c = 8'($urandom_range(0, 255));
            v = sextet_of(c);
        end
        while (!v[6] || c == b64d_pkg::NEWLINE_CODE);
        return c;
    endfunction

    // one random stream: mostly well formed, some broken, some noise
    task automatic send_random_stream(output int counted);
        logic [7:0] symbols[$];
        logic [7:0] wire_chars[$];
        int         kind;
        int         groups;
        int         pad;
        kind    = $urandom_range(0, 99);
        groups  = $urandom_range(1, 3);
        counted = 0;
        for (int i = 0; i < groups * 4; i++)
        begin
            symbols.push_back(random_symbol());
        end
        // padding on the final group, odd padding included
        pad = $urandom_range(0, 3);
        if (pad == 1)
        begin
            symbols[symbols.size() - 1] = b64d_pkg::PAD_CODE;
        end
        else if (pad == 2)
        begin
            symbols[symbols.size() - 1] = b64d_pkg::PAD_CODE;
            symbols[symbols.size() - 2] = b64d_pkg::PAD_CODE;
        end
        else if (pad == 3)
        begin
            symbols[symbols.size() - 2] = b64d_pkg::PAD_CODE;
        end
        // pad in the first group, decoded as zero when more groups follow
        if ($urandom_range(0, 9) == 0)
        begin
            symbols[$urandom_range(0, 3)] = b64d_pkg::PAD_CODE;
        end

        if (kind < 70)
        begin
            // well formed, nothing more to do
        end
        else if (kind < 80)
        begin
            // length not a multiple of four
            if ($urandom_range(0, 1) == 1)
            begin
                repeat ($urandom_range(1, 3)) symbols.push_back(random_symbol());
            end
            else
            begin
                repeat ($urandom_range(1, 3)) void'(symbols.pop_back());
            end
        end
        else if (kind < 90)
        begin
            symbols[$urandom_range(0, symbols.size() - 1)] = random_bad_byte();
        end
        else if (kind < 95)
        begin
            symbols.delete();
        end
        else
        begin
            symbols.delete();
            repeat ($urandom_range(1, 6)) symbols.push_back(8'($urandom_range(0, 255)));
        end

        // sprinkle newlines, sometimes one at the very end
        foreach (symbols[i])
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                wire_chars.push_back(b64d_pkg::NEWLINE_CODE);
            end
            wire_chars.push_back(symbols[i]);
        end
        if (wire_chars.size() == 0 || $urandom_range(0, 7) == 0)
        begin
            wire_chars.push_back(b64d_pkg::NEWLINE_CODE);
        end

        // every character sent counts towards the phase total
        counted = wire_chars.size();

        foreach (wire_chars[i])
        begin
            send_char(wire_chars[i], i == wire_chars.size() - 1);
        end
    endtask

    task automatic run_random_streams(input int target);
        int total;
        int n;
        total = 0;
        while (total < target)
        begin
            send_random_stream(n);
            total += n;
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_directed_streams();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        // alphabet extremes, pads inside a group that is not final, one trailing pad
        send_stream("az==/+09AZ8=");
        // odd padding, stream ended by a newline
        send_stream("AB=C\n");
        // nothing but a newline: empty stream
        send_stream("\n");
        // bad character mid stream, rest discarded up to the last flag
        send_char("Q", 1'b0);
        send_char(8'h00, 1'b0);
        send_char("A", 1'b1);
        // partial group at the end
        send_stream("Zm");
        // bad character as the final transfer
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_back_to_back();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        run_random_streams(PHASE_ITEMS);
    endtask

    task automatic test_sender_gaps();
        tx_idle_pct  = 65;
        rx_stall_pct = 0;
        run_random_streams(PHASE_ITEMS);
    endtask

    task automatic test_receiver_stalls();
        tx_idle_pct  = 0;
        rx_stall_pct = 65;
        run_random_streams(PHASE_ITEMS);
    endtask

    task automatic test_both_idle();
        tx_idle_pct  = 24;
        rx_stall_pct = 24;
        run_random_streams(PHASE_ITEMS);
    endtask

    initial
    begin
        clear_decoder();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_streams();
        wait_for_results();
        test_back_to_back();
        wait_for_results();
        test_sender_gaps();
        wait_for_results();
        test_receiver_stalls();
        wait_for_results();
        test_both_idle();
        wait_for_results();

        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64_stream_decoder_core.sv
test/tb_base64_stream_decoder_core.sv
